### rtl/ring_buffer_chunk_dispenser_assert.svh
// Assertion macros shared by the ring buffer chunk dispenser RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef RING_BUFFER_CHUNK_DISPENSER_ASSERT_SVH
`define RING_BUFFER_CHUNK_DISPENSER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset.
`define RBCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbcd assertion failed");
// Next-cycle implication, disabled while in reset.
`define RBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbcd assertion failed");
`else
`define RBCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RBCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/rbcd_pkg.sv
// Types and codes for the ring buffer chunk dispenser.
// No dependencies; used by the interfaces, the core and the top level.
`timescale 1ns / 1ps

package rbcd_pkg;

    typedef enum logic [1:0] {
        REQ_WRITE      = 2'd0,
        REQ_CHUNK      = 2'd1,
        REQ_DISC_BEGIN = 2'd2,
        REQ_DISC_END   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [16:0] write_size;
    } t_req;

    typedef struct packed {
        logic        write_accepted;
        logic        chunk_granted;
        logic [15:0] chunk_offset;
        logic [12:0] chunk_bytes;
        logic [16:0] fill_level;
        logic        consumer_starved;
        logic        consumer_waiting;
        logic        discard_complete;
    } t_res;

    // Top level to core: pipeline advance plus the registered item.
    typedef struct packed {
        logic advance;
        t_req req;
    } t_core_ctl;

endpackage

### rtl/rbcd_req_if.sv
// Request channel: valid/ready handshake carrying one rbcd_pkg::t_req item.
// Depends on rbcd_pkg.
`timescale 1ns / 1ps

interface rbcd_req_if;
    logic          valid;
    logic          ready;
    rbcd_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/rbcd_res_if.sv
// Result channel: valid/ready handshake carrying one rbcd_pkg::t_res item.
// Depends on rbcd_pkg.
`timescale 1ns / 1ps

interface rbcd_res_if;
    logic          valid;
    logic          ready;
    rbcd_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ring_buffer_chunk_dispenser.sv
// Ring buffer chunk dispenser top level: input register, core, result register.
// Depends on rbcd_pkg, rbcd_req_if, rbcd_res_if, rbcd_core and the assert header.
//
// Usage:
//   i_req  carries requests (write, chunk request, begin or end discard) with
//          a write size; o_res returns exactly one result item per request.
//   i_cfg_we / i_cfg_wdata write output_enabled; write only while idle.
//   A request is registered in the input register on acceptance, processed
//   by the core when the pipeline advances and lands in the result
//   register, which drives o_res.valid; a stall of o_res holds it in the
//   input register until the result register can take it.
//   Throughput is one item per cycle while o_res takes results; the pointer
//   update is combinational logic on the core's pointer and fill registers.
//   When o_res stalls, one item waits in the result register and one in the
//   input register; i_req.ready drops only when both are full.
//   Reset (i_rst_n low, synchronous) empties both registers, zeroes the
//   pointers, fill level and flags, and clears output_enabled.
`timescale 1ns / 1ps
`include "ring_buffer_chunk_dispenser_assert.svh"

module ring_buffer_chunk_dispenser #(
    parameter int BUFFER_BYTES = 65536,
    parameter int CHUNK_BYTES  = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    rbcd_req_if.sink    i_req,
    rbcd_res_if.source  o_res
);

    logic                r_in_valid;
    rbcd_pkg::t_req      r_in;
    logic                r_out_valid;
    rbcd_pkg::t_res      r_out;
    logic                w_adv;
    rbcd_pkg::t_core_ctl w_ctl;
    rbcd_pkg::t_res      w_res;

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || w_adv;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        w_ctl.advance = w_adv;
        w_ctl.req     = r_in;
    end

    rbcd_core #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .CHUNK_BYTES  (CHUNK_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctl       (w_ctl),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    `RBCD_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_valid)
    `RBCD_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !o_res.ready, !w_adv)
    `RBCD_ASSERT_NEXT(a_stall_holds_in, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid && $stable(r_in))

endmodule

### rtl/rbcd_core.sv
// Pointer state and single-pass request logic of the chunk dispenser.
// Depends on rbcd_pkg and ring_buffer_chunk_dispenser_assert.svh.
`timescale 1ns / 1ps
`include "ring_buffer_chunk_dispenser_assert.svh"

module rbcd_core #(
    parameter int BUFFER_BYTES = 65536,
    parameter int CHUNK_BYTES  = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  rbcd_pkg::t_core_ctl i_ctl,
    output rbcd_pkg::t_res      o_res
);

    localparam int PW = $clog2(2 * BUFFER_BYTES);   // position width
    localparam int FW = $clog2(BUFFER_BYTES + 1);   // fill width
    localparam int CW = $clog2(CHUNK_BYTES + 1);    // chunk length width
    localparam logic [PW:0]   SPAN  = (PW + 1)'(2 * BUFFER_BYTES);
    localparam logic [PW-1:0] BUF_P = PW'(BUFFER_BYTES);
    localparam logic [FW-1:0] BUF_F = FW'(BUFFER_BYTES);

    logic [PW-1:0] r_rp, n_rp;
    logic [PW-1:0] r_wp, n_wp;
    logic [FW-1:0] r_fill, n_fill;   // always wp - rp modulo the span
    logic [CW-1:0] r_pending, n_pending;
    logic          r_in_flight, n_in_flight;
    logic          r_waiting, n_waiting;
    logic          r_starved, n_starved;
    logic          r_discarding, n_discarding;
    logic          r_out_en;

    logic [FW-1:0] commit_f;
    logic [PW:0]   rp_sum;
    logic [PW-1:0] rp_c;
    logic [PW-1:0] rp_g;
    logic [FW-1:0] fill_g;
    logic [PW-1:0] off;
    logic [FW-1:0] to_wrap;
    logic [31:0]   n_min;
    logic [FW-1:0] free_b;
    logic          wr_ok;
    logic [PW:0]   wp_sum;
    logic          grant;

    always_comb begin
        // commit the chunk granted before, then apply a discard
        commit_f = r_in_flight ? FW'(r_pending) : '0;
        rp_sum   = {1'b0, r_rp} + (PW + 1)'(commit_f);
        rp_c     = (rp_sum >= SPAN) ? PW'(rp_sum - SPAN) : PW'(rp_sum);
        rp_g     = r_discarding ? r_wp : rp_c;
        fill_g   = r_discarding ? '0 : (r_fill - commit_f);
        off      = (rp_g >= BUF_P) ? (rp_g - BUF_P) : rp_g;
        to_wrap  = BUF_F - FW'(off);
        n_min    = 32'(fill_g);
        if (32'(to_wrap) < n_min) begin
            n_min = 32'(to_wrap);
        end
        if (32'(CHUNK_BYTES) < n_min) begin
            n_min = 32'(CHUNK_BYTES);
        end
        grant    = r_out_en && (fill_g != '0);

        free_b   = BUF_F - r_fill;
        wr_ok    = !r_discarding && (32'(i_ctl.req.write_size) <= 32'(free_b));
        wp_sum   = {1'b0, r_wp} + (PW + 1)'(i_ctl.req.write_size);
    end

    always_comb begin
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_fill       = r_fill;
        n_pending    = r_pending;
        n_in_flight  = r_in_flight;
        n_waiting    = r_waiting;
        n_starved    = r_starved;
        n_discarding = r_discarding;
        o_res                = '0;

        unique case (i_ctl.req.req_type)
            rbcd_pkg::REQ_WRITE: begin
                if (wr_ok) begin
                    n_wp   = (wp_sum >= SPAN) ? PW'(wp_sum - SPAN) : PW'(wp_sum);
                    n_fill = r_fill + FW'(i_ctl.req.write_size);
                    o_res.write_accepted = 1'b1;
                end
            end
            rbcd_pkg::REQ_CHUNK: begin
                n_rp        = rp_g;
                n_fill      = fill_g;
                n_in_flight = 1'b0;
                if (grant) begin
                    if (!r_waiting) begin
                        n_starved = 1'b0;
                    end
                    n_waiting   = 1'b0;
                    n_pending   = CW'(n_min);
                    n_in_flight = 1'b1;
                    o_res.chunk_granted = 1'b1;
                    o_res.chunk_offset  = 16'(off);
                    o_res.chunk_bytes   = 13'(n_min);
                end else begin
                    if (r_waiting) begin
                        n_starved = 1'b1;
                    end
                    n_waiting = 1'b1;
                end
            end
            rbcd_pkg::REQ_DISC_BEGIN: n_discarding = 1'b1;
            rbcd_pkg::REQ_DISC_END:   n_discarding = 1'b0;
            default: ;
        endcase

        o_res.fill_level       = 17'(n_fill);
        o_res.consumer_starved = n_starved;
        o_res.consumer_waiting = n_waiting;
        o_res.discard_complete = n_discarding && (n_fill == '0) && n_starved;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp         <= '0;
            r_wp         <= '0;
            r_fill       <= '0;
            r_pending    <= '0;
            r_in_flight  <= 1'b0;
            r_waiting    <= 1'b0;
            r_starved    <= 1'b0;
            r_discarding <= 1'b0;
            r_out_en     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_out_en <= i_cfg_wdata;
            end
            if (i_ctl.advance) begin
                r_rp         <= n_rp;
                r_wp         <= n_wp;
                r_fill       <= n_fill;
                r_pending    <= n_pending;
                r_in_flight  <= n_in_flight;
                r_waiting    <= n_waiting;
                r_starved    <= n_starved;
                r_discarding <= n_discarding;
            end
        end
    end

    `RBCD_ASSERT_IMPL(a_fill_max, i_clk, i_rst_n, 1'b1, r_fill <= BUF_F)
    `RBCD_ASSERT_IMPL(a_pend_fits, i_clk, i_rst_n, r_in_flight, (r_pending != '0) && (FW'(r_pending) <= r_fill))
    `RBCD_ASSERT_IMPL(a_wait_xor_flight, i_clk, i_rst_n, r_waiting, !r_in_flight)

endmodule
